// ===== hdl/adc_trigger_router_fifo_top_defines.svh =====
// ----------------------------------------------------------------------------
// adc_trigger_router_fifo_top_defines
// Assertion macros for the trigger router; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ADC_TRIGGER_ROUTER_FIFO_TOP_DEFINES_SVH
`define ADC_TRIGGER_ROUTER_FIFO_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define ATR_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("atr assertion failed");
`define ATR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("atr next-cycle assertion failed");
`else
`define ATR_ASSERT(lbl, clk_s, rst_s, prop)
`define ATR_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

// ===== hdl/atr_pkg.sv =====
// ----------------------------------------------------------------------------
// atr_pkg
// Types, register map and helper functions of the ADC trigger router.
// ----------------------------------------------------------------------------
`default_nettype none

package atr_pkg;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TRIG  = 2'd2,
    CMD_DONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [13:0] addr;
    logic [31:0] wdata;
    logic [2:0]  line;
    logic        level;
    logic [11:0] adc_result;
  } in_item_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic        irq;
    logic        trig_fire;
    logic [1:0]  trig_adc;
    logic [2:0]  trig_channel;
  } out_item_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [14:0] data;
  } fifo_req_t;

  localparam logic [13:0] ADDR_MCR       = 14'h000;
  localparam logic [13:0] ADDR_TRIG_BASE = 14'h018;
  localparam logic [13:0] ADDR_SWTRIG    = 14'h22C;
  localparam logic [13:0] ADDR_FIFO_DATA = 14'h450;
  localparam logic [13:0] ADDR_FIFO_CTL  = 14'h460;
  localparam logic [13:0] ADDR_WMARK     = 14'h464;
  localparam logic [13:0] ADDR_WM_FLAG   = 14'h468;
  localparam logic [13:0] ADDR_FIFO_STAT = 14'h46C;
  localparam logic [13:0] ADDR_FIFO_CNT  = 14'h470;

  localparam int MCR_MDIS_BIT  = 30;
  localparam int TRG_EN_BIT    = 15;
  localparam int TRG_ADC_LSB   = 8;
  localparam int TRG_MASK_W    = 7;
  localparam int FIFO_VLD_BIT  = 19;
  localparam int FIFO_CHN_LSB  = 20;
  localparam int CTL_IE_BIT    = 16;
  localparam int CTL_KEEP_LSB  = 24;
  localparam int WM_FLAG_BIT   = 16;
  localparam logic [3:0] WMARK_RST = 4'd4;

  function automatic logic [4:0] low_bit32(input logic [31:0] v);
    logic [4:0] r;
    r = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) begin
        r = 5'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [2:0] low_bit7(input logic [6:0] v);
    logic [2:0] r;
    r = 3'd0;
    for (int i = 6; i >= 0; i--) begin
      if (v[i]) begin
        r = 3'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/atr_fifo.sv =====
// ----------------------------------------------------------------------------
// atr_fifo
// Result FIFO with a registered head word and write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module atr_fifo #(
  parameter int FIFO_DEPTH = 16
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  atr_pkg::fifo_req_t              req,
  output logic [$clog2(FIFO_DEPTH+1)-1:0] cnt,
  output logic [14:0]                     head_data
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int HW = $clog2(FIFO_DEPTH);

  logic [14:0]   mem [FIFO_DEPTH];
  logic [HW-1:0] head_r;
  logic [HW-1:0] head_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [CW:0]   tail_sum;
  logic [HW-1:0] tail;
  logic [14:0]   rd_r;

  always_comb begin
    tail_sum = (CW+1)'(head_r) + (CW+1)'(cnt_r);
    if (tail_sum >= (CW+1)'(FIFO_DEPTH)) begin
      tail = HW'(tail_sum - (CW+1)'(FIFO_DEPTH));
    end else begin
      tail = HW'(tail_sum);
    end
    head_nxt = head_r;
    if (req.pop) begin
      head_nxt = (head_r == HW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(req.push) - CW'(req.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[tail] <= req.data;
    end
    if (req.push && (tail == head_nxt)) begin
      rd_r <= req.data;
    end else begin
      rd_r <= mem[head_nxt];
    end
  end

  assign cnt       = cnt_r;
  assign head_data = rd_r;

endmodule

`default_nettype wire

// ===== hdl/atr_core.sv =====
// ----------------------------------------------------------------------------
// atr_core
// Register file, trigger routing, done matching and read mux for one event.
// ----------------------------------------------------------------------------
`default_nettype none

module atr_core #(
  parameter int NUM_TRIGGERS = 8,
  parameter int FIFO_DEPTH   = 16,
  parameter int NUM_ADCS     = 3
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             go,
  input  atr_pkg::in_item_t               item,
  input  wire [$clog2(FIFO_DEPTH+1)-1:0]  fifo_cnt,
  input  wire [14:0]                      fifo_head,
  output atr_pkg::fifo_req_t              fifo_req,
  output atr_pkg::out_item_t              result
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int TW = (NUM_TRIGGERS > 1) ? $clog2(NUM_TRIGGERS) : 1;
  localparam logic [13:0] TRIG_END =
    14'(int'(atr_pkg::ADDR_TRIG_BASE) + 4 * NUM_TRIGGERS);

  logic [31:0]   trig_cfg_r [NUM_TRIGGERS];
  logic          mod_dis_r, mod_dis_nxt;
  logic [2:0]    fifo_ctl_r, fifo_ctl_nxt;
  logic [3:0]    wm_r, wm_nxt;
  logic          wm_flag_r, wm_flag_nxt;
  logic          pend_vld_r, pend_vld_nxt;
  logic [2:0]    pend_adc_r, pend_adc_nxt;
  logic [2:0]    pend_chn_r, pend_chn_nxt;

  logic          is_rd, is_wr;
  logic          trig_hit;
  logic [13:0]   trig_off;
  logic [TW-1:0] cfg_idx;
  logic          cfg_we;
  logic [4:0]    sw_num;
  logic          fire_req;
  logic [4:0]    fire_num;
  logic [31:0]   fire_cfg;
  logic [2:0]    fire_adc;
  logic [2:0]    fire_chn;
  logic          fire_ok;
  logic          done_hit;
  logic [CW-1:0] cnt_after;
  logic [31:0]   rd_val;

  always_comb begin
    is_rd    = go && (item.cmd == atr_pkg::CMD_READ);
    is_wr    = go && (item.cmd == atr_pkg::CMD_WRITE);
    trig_hit = (item.addr >= atr_pkg::ADDR_TRIG_BASE) && (item.addr < TRIG_END);
    trig_off = item.addr - atr_pkg::ADDR_TRIG_BASE;
    cfg_idx  = trig_off[TW+1:2];
    cfg_we   = is_wr && trig_hit;
    sw_num   = atr_pkg::low_bit32(item.wdata);

    fire_req = 1'b0;
    fire_num = {2'b00, item.line};
    if (go && (item.cmd == atr_pkg::CMD_TRIG)) begin
      fire_req = item.level && (32'(item.line) < NUM_TRIGGERS);
    end else if (is_wr && (item.addr == atr_pkg::ADDR_SWTRIG)) begin
      fire_req = (item.wdata != '0) && (32'(sw_num) < NUM_TRIGGERS);
      fire_num = sw_num;
    end
    fire_cfg = trig_cfg_r[fire_num[TW-1:0]];
    fire_adc = fire_cfg[atr_pkg::TRG_ADC_LSB +: 3];
    fire_chn = atr_pkg::low_bit7(fire_cfg[atr_pkg::TRG_MASK_W-1:0]);
    fire_ok  = fire_req && fire_cfg[atr_pkg::TRG_EN_BIT] && !mod_dis_r &&
               (32'(fire_adc) < NUM_ADCS);

    done_hit = go && (item.cmd == atr_pkg::CMD_DONE) && item.level &&
               (32'(item.line) < NUM_ADCS) && pend_vld_r && (pend_adc_r == item.line);

    fifo_req.push = done_hit && (32'(fifo_cnt) < FIFO_DEPTH);
    fifo_req.pop  = is_rd && (item.addr == atr_pkg::ADDR_FIFO_DATA) && (fifo_cnt != '0);
    fifo_req.data = {pend_chn_r, item.adc_result};
    cnt_after     = fifo_cnt + CW'(fifo_req.push);

    mod_dis_nxt  = mod_dis_r;
    fifo_ctl_nxt = fifo_ctl_r;
    wm_nxt       = wm_r;
    wm_flag_nxt  = wm_flag_r;
    pend_vld_nxt = pend_vld_r;
    pend_adc_nxt = pend_adc_r;
    pend_chn_nxt = pend_chn_r;

    if (is_wr && !trig_hit) begin
      unique case (item.addr)
        atr_pkg::ADDR_MCR: begin
          mod_dis_nxt = item.wdata[atr_pkg::MCR_MDIS_BIT];
        end
        atr_pkg::ADDR_FIFO_CTL: begin
          fifo_ctl_nxt = {item.wdata[atr_pkg::CTL_KEEP_LSB +: 2],
                          item.wdata[atr_pkg::CTL_IE_BIT]};
        end
        atr_pkg::ADDR_WMARK: begin
          wm_nxt = item.wdata[3:0];
        end
        atr_pkg::ADDR_WM_FLAG: begin
          if (item.wdata[atr_pkg::WM_FLAG_BIT]) begin
            wm_flag_nxt = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (fire_ok) begin
      pend_vld_nxt = 1'b1;
      pend_adc_nxt = fire_adc;
      pend_chn_nxt = fire_chn;
    end

    if (done_hit) begin
      pend_vld_nxt = 1'b0;
      if (32'(cnt_after) > 32'(wm_r)) begin
        wm_flag_nxt = 1'b1;
      end
    end

    rd_val = '0;
    if (trig_hit) begin
      rd_val = trig_cfg_r[cfg_idx];
    end else begin
      unique case (item.addr)
        atr_pkg::ADDR_MCR: begin
          rd_val[atr_pkg::MCR_MDIS_BIT] = mod_dis_r;
        end
        atr_pkg::ADDR_FIFO_DATA: begin
          if (fifo_cnt != '0) begin
            rd_val[11:0]                        = fifo_head[11:0];
            rd_val[atr_pkg::FIFO_CHN_LSB +: 3]  = fifo_head[14:12];
            rd_val[atr_pkg::FIFO_VLD_BIT]       = 1'b1;
          end
        end
        atr_pkg::ADDR_FIFO_CTL: begin
          rd_val[atr_pkg::CTL_IE_BIT]        = fifo_ctl_r[0];
          rd_val[atr_pkg::CTL_KEEP_LSB +: 2] = fifo_ctl_r[2:1];
        end
        atr_pkg::ADDR_WMARK: begin
          rd_val[3:0] = wm_r;
        end
        atr_pkg::ADDR_WM_FLAG: begin
          rd_val[atr_pkg::WM_FLAG_BIT] = wm_flag_r;
        end
        atr_pkg::ADDR_FIFO_STAT: begin
          rd_val[0] = (fifo_cnt != '0);
        end
        atr_pkg::ADDR_FIFO_CNT: begin
          rd_val = 32'(fifo_cnt);
        end
        default: begin
        end
      endcase
    end

    result.rdata        = is_rd ? rd_val : '0;
    result.irq          = wm_flag_nxt && fifo_ctl_nxt[0];
    result.trig_fire    = fire_ok;
    result.trig_adc     = fire_ok ? fire_adc[1:0] : 2'd0;
    result.trig_channel = fire_ok ? fire_chn : 3'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TRIGGERS; i++) begin
        trig_cfg_r[i] <= '0;
      end
      mod_dis_r  <= 1'b0;
      fifo_ctl_r <= '0;
      wm_r       <= atr_pkg::WMARK_RST;
      wm_flag_r  <= 1'b0;
      pend_vld_r <= 1'b0;
      pend_adc_r <= '0;
      pend_chn_r <= '0;
    end else begin
      if (cfg_we) begin
        trig_cfg_r[cfg_idx] <= item.wdata;
      end
      mod_dis_r  <= mod_dis_nxt;
      fifo_ctl_r <= fifo_ctl_nxt;
      wm_r       <= wm_nxt;
      wm_flag_r  <= wm_flag_nxt;
      pend_vld_r <= pend_vld_nxt;
      pend_adc_r <= pend_adc_nxt;
      pend_chn_r <= pend_chn_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/adc_trigger_router_fifo_top.sv =====
// ----------------------------------------------------------------------------
// adc_trigger_router_fifo_top
// Path: an accepted input goes through the input register, then the result
// register, where out_valid rises; out_stall, while out_valid is high, holds both.
// Throughput: one transaction per cycle unless out_stall holds the output, set by the single-pass event logic.
// Reset: synchronous active-low rst_n clears all control and register state;
// watermark resets to four, FIFO contents stay undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none
`include "adc_trigger_router_fifo_top_defines.svh"

module adc_trigger_router_fifo_top #(
  parameter int NUM_TRIGGERS = 8,
  parameter int FIFO_DEPTH   = 16,
  parameter int NUM_ADCS     = 3
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  atr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output atr_pkg::out_item_t out_data
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic               in_vld_r;
  atr_pkg::in_item_t  in_r;
  logic               out_vld_r;
  atr_pkg::out_item_t out_r;
  logic               advance;
  atr_pkg::fifo_req_t fifo_req;
  logic [CW-1:0]      fifo_cnt;
  logic [14:0]        fifo_head;
  atr_pkg::out_item_t result;

  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= result;
    end
  end

  atr_core #(
    .NUM_TRIGGERS (NUM_TRIGGERS),
    .FIFO_DEPTH   (FIFO_DEPTH),
    .NUM_ADCS     (NUM_ADCS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (advance),
    .item      (in_r),
    .fifo_cnt  (fifo_cnt),
    .fifo_head (fifo_head),
    .fifo_req  (fifo_req),
    .result    (result)
  );

  atr_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (fifo_req),
    .cnt       (fifo_cnt),
    .head_data (fifo_head)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `ATR_ASSERT(a_fifo_cnt_max, clk, rst_n, 32'(fifo_cnt) <= FIFO_DEPTH)
  `ATR_ASSERT_NEXT(a_in_hold, clk, rst_n, in_vld_r && !advance, in_vld_r && $stable(in_r))
  `ATR_ASSERT(a_trig_adc_range, clk, rst_n,
              out_vld_r && out_r.trig_fire |-> 32'(out_r.trig_adc) < NUM_ADCS)

endmodule

`default_nettype wire
